>>> rtl/timing_wheel_timeout_table_assert.svh
// ----------------------------------------------------------------------------
// timing_wheel_timeout_table_assert
// Assertion macros shared by the timeout table RTL.
// ----------------------------------------------------------------------------
`ifndef TIMING_WHEEL_TIMEOUT_TABLE_ASSERT_SVH
`define TIMING_WHEEL_TIMEOUT_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TTW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timeout table check failed");

// Next-cycle implication, checked out of reset.
`define TTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timeout table check failed");

`endif

>>> rtl/ttw_pkg.sv
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared types, codes and constants of the timing wheel timeout table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttw_pkg;

    localparam int DEF_NUM_HANDLES = 64;
    localparam int DEF_WHEEL_SLOTS = 60;
    localparam int MAX_RESULTS     = 64;
    localparam int CNT_W           = $clog2(MAX_RESULTS);

    localparam int OPCODE_W   = 3;
    localparam int HANDLE_W   = 6;
    localparam int TAG_W      = 32;
    localparam int DELAY_W    = 24;
    localparam int TIME_W     = 32;
    localparam int KIND_W     = 2;

    localparam logic [OPCODE_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REARM  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CANCEL = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_FREE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MOD_WAIT,
        S_COMMIT,
        S_LOOKUP_RD,
        S_RESP,
        S_RESP_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic mod_start;
        logic mod_src_now;
        logic commit;
        logic do_cancel;
        logic do_free;
        logic rd;
        logic rd_scan;
        logic scan_clr;
        logic scan_next;
        logic expire;
        logic load_resp;
        logic load_done;
    } t_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                in_range;
        logic                present;
        logic                mod_busy;
        logic                hit;
        logic                scan_end;
        logic                out_valid;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/timing_wheel_timeout_table.sv
// ----------------------------------------------------------------------------
// timing_wheel_timeout_table
// One-shot per-handle timeouts kept on a seconds timing wheel.
// ----------------------------------------------------------------------------
// One beat is handled at a time. Create and rearm wait on a reciprocal-multiply
// remainder unit for the wheel slot of the new deadline. A tick first works out
// the slot of the current time, then reads the entries one by one on the single
// read port of the entry store, and for each expired timer waits until its
// result beat has been taken, through any output stall.
`timescale 1ns / 1ps
`default_nettype none

module timing_wheel_timeout_table #(
    parameter int NUM_HANDLES = ttw_pkg::DEF_NUM_HANDLES,
    parameter int WHEEL_SLOTS = ttw_pkg::DEF_WHEEL_SLOTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [ttw_pkg::OPCODE_W-1:0]   i_opcode,
    input  wire logic [ttw_pkg::HANDLE_W-1:0]   i_handle,
    input  wire logic [ttw_pkg::TAG_W-1:0]      i_user_tag,
    input  wire logic [ttw_pkg::DELAY_W-1:0]    i_delay_seconds,
    input  wire logic [ttw_pkg::TIME_W-1:0]     i_now_seconds,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [ttw_pkg::KIND_W-1:0]          o_kind,
    output logic                                o_status,
    output logic [ttw_pkg::HANDLE_W-1:0]        o_out_handle,
    output logic [ttw_pkg::TAG_W-1:0]           o_out_tag,
    output logic [ttw_pkg::TIME_W-1:0]          o_out_deadline,
    output logic                                o_present,
    output logic                                o_armed,
    output logic                                o_last
);
    import ttw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ttw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ttw_dp #(
        .NUM_HANDLES (NUM_HANDLES),
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_handle        (i_handle),
        .i_user_tag      (i_user_tag),
        .i_delay_seconds (i_delay_seconds),
        .i_now_seconds   (i_now_seconds),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_out_handle    (o_out_handle),
        .o_out_tag       (o_out_tag),
        .o_out_deadline  (o_out_deadline),
        .o_present       (o_present),
        .o_armed         (o_armed),
        .o_last          (o_last)
    );

`include "timing_wheel_timeout_table_assert.svh"

    `TTW_ASSERT_SAME(a_idle_no_result, i_clk, i_rst_n, !o_stall, !o_valid)
    `TTW_ASSERT_SAME(a_expired_not_last, i_clk, i_rst_n, o_valid && o_kind == KIND_EXPIRED, !o_last)
    `TTW_ASSERT_SAME(a_lookup_last, i_clk, i_rst_n, o_valid && o_kind == KIND_LOOKUP, o_last)
    `TTW_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

`default_nettype wire

>>> rtl/ttw_rem.sv
// ----------------------------------------------------------------------------
// ttw_rem
// Remainder of a 32-bit value by the wheel size, by reciprocal multiplication:
// the quotient is registered first, then the remainder is registered from it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttw_rem #(
    parameter int WHEEL_SLOTS = ttw_pkg::DEF_WHEEL_SLOTS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [ttw_pkg::TIME_W-1:0]       i_dividend,
    output logic                                  o_busy,
    output logic [$clog2(WHEEL_SLOTS)-1:0]        o_rem
);
    import ttw_pkg::*;

    localparam int SW = $clog2(WHEEL_SLOTS);
    localparam int PW = 2 * TIME_W + 1;
    localparam int QW = TIME_W + 1 - SW;
    localparam logic [PW-1:0] ONE   = PW'(1);
    localparam logic [PW-1:0] DIV   = PW'(WHEEL_SLOTS);
    localparam logic [PW-1:0] MAGIC = ((ONE << (TIME_W + SW)) + DIV - ONE) / DIV;

    logic [TIME_W-1:0] r_x;
    logic [QW-1:0]     r_q;
    logic              r_pend;
    logic [SW-1:0]     r_rem;
    logic [PW-1:0]     prod;
    logic [TIME_W-1:0] back;
    logic [TIME_W-1:0] diff;

    assign prod = PW'(i_dividend) * MAGIC;
    assign back = TIME_W'(r_q) * TIME_W'(WHEEL_SLOTS);
    assign diff = r_x - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
            r_q <= prod[PW-1:TIME_W+SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_rem <= diff[SW-1:0];
        end
    end

    assign o_busy = r_pend;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/ttw_ctrl.sv
// ----------------------------------------------------------------------------
// ttw_ctrl
// Sequencer of the timeout table: decodes each beat and steps the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire ttw_pkg::t_sts i_sts,
    output ttw_pkg::t_cmd      o_cmd
);
    import ttw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_CREATE: n_state = i_sts.in_range ? S_MOD_WAIT : S_RESP;
                    OP_REARM:  n_state = i_sts.present ? S_MOD_WAIT : S_RESP;
                    OP_LOOKUP: n_state = S_LOOKUP_RD;
                    OP_TICK:   n_state = S_MOD_WAIT;
                    default:   n_state = S_RESP;
                endcase
            end
            S_MOD_WAIT: begin
                if (!i_sts.mod_busy) begin
                    n_state = (i_sts.op == OP_TICK) ? S_SCAN_RD : S_COMMIT;
                end
            end
            S_COMMIT:    n_state = S_RESP;
            S_LOOKUP_RD: n_state = S_RESP;
            S_RESP:      n_state = S_RESP_WAIT;
            S_RESP_WAIT: begin
                if (!i_sts.out_valid) n_state = S_IDLE;
            end
            S_SCAN_RD:   n_state = i_sts.scan_end ? S_DONE : S_SCAN_CHK;
            S_SCAN_CHK:  n_state = i_sts.hit ? S_SCAN_WAIT : S_SCAN_RD;
            S_SCAN_WAIT: begin
                if (!i_sts.out_valid) n_state = S_SCAN_RD;
            end
            S_DONE:      n_state = S_RESP_WAIT;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_valid;
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_CREATE: o_cmd.mod_start = i_sts.in_range;
                    OP_REARM:  o_cmd.mod_start = i_sts.present;
                    OP_CANCEL: o_cmd.do_cancel = i_sts.present;
                    OP_FREE:   o_cmd.do_free   = i_sts.present;
                    OP_LOOKUP: o_cmd.rd        = 1'b1;
                    OP_TICK: begin
                        o_cmd.mod_start   = 1'b1;
                        o_cmd.mod_src_now = 1'b1;
                        o_cmd.scan_clr    = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_COMMIT:  o_cmd.commit    = 1'b1;
            S_RESP:    o_cmd.load_resp = 1'b1;
            S_SCAN_RD: begin
                o_cmd.rd      = !i_sts.scan_end;
                o_cmd.rd_scan = 1'b1;
            end
            S_SCAN_CHK: begin
                o_cmd.expire    = i_sts.hit;
                o_cmd.scan_next = !i_sts.hit;
            end
            S_SCAN_WAIT: o_cmd.scan_next = !i_sts.out_valid;
            S_DONE:      o_cmd.load_done = 1'b1;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/ttw_dp.sv
// ----------------------------------------------------------------------------
// ttw_dp
// Datapath of the timeout table: entry store, flags, scan and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttw_dp #(
    parameter int NUM_HANDLES = ttw_pkg::DEF_NUM_HANDLES,
    parameter int WHEEL_SLOTS = ttw_pkg::DEF_WHEEL_SLOTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ttw_pkg::t_cmd                  i_cmd,
    output ttw_pkg::t_sts                       o_sts,
    input  wire logic [ttw_pkg::OPCODE_W-1:0]   i_opcode,
    input  wire logic [ttw_pkg::HANDLE_W-1:0]   i_handle,
    input  wire logic [ttw_pkg::TAG_W-1:0]      i_user_tag,
    input  wire logic [ttw_pkg::DELAY_W-1:0]    i_delay_seconds,
    input  wire logic [ttw_pkg::TIME_W-1:0]     i_now_seconds,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [ttw_pkg::KIND_W-1:0]          o_kind,
    output logic                                o_status,
    output logic [ttw_pkg::HANDLE_W-1:0]        o_out_handle,
    output logic [ttw_pkg::TAG_W-1:0]           o_out_tag,
    output logic [ttw_pkg::TIME_W-1:0]          o_out_deadline,
    output logic                                o_present,
    output logic                                o_armed,
    output logic                                o_last
);
    import ttw_pkg::*;

    localparam int HW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
    localparam int CW = $clog2(NUM_HANDLES + 1);
    localparam int SW = $clog2(WHEEL_SLOTS);

    logic [OPCODE_W-1:0]    r_op;
    logic [HANDLE_W-1:0]    r_handle;
    logic [TAG_W-1:0]       r_tag;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      r_dl;
    logic                   r_in_range;
    logic                   r_present;
    logic [NUM_HANDLES-1:0] r_valid;
    logic [NUM_HANDLES-1:0] r_armed;
    logic [CW-1:0]          r_scan;
    logic [CNT_W-1:0]       r_cnt;
    logic [TIME_W-1:0]      r_rd_dl;
    logic [TAG_W-1:0]       r_rd_tag;
    logic [SW-1:0]          r_rd_slot;

    logic [TIME_W-1:0] mem_dl   [NUM_HANDLES];
    logic [TAG_W-1:0]  mem_tag  [NUM_HANDLES];
    logic [SW-1:0]     mem_slot [NUM_HANDLES];

    logic [TIME_W:0]   sum;
    logic              in_range;
    logic [HW-1:0]     in_idx;
    logic [HW-1:0]     h_idx;
    logic [HW-1:0]     s_idx;
    logic [HW-1:0]     rd_addr;
    logic              mod_busy;
    logic [SW-1:0]     rem;
    logic              err;
    logic              is_lookup;
    logic              take;

    assign sum      = {1'b0, i_now_seconds} + {{(TIME_W + 1 - DELAY_W){1'b0}}, i_delay_seconds};
    assign in_range = ({1'b0, i_handle} < (HANDLE_W + 1)'(NUM_HANDLES));
    assign in_idx   = i_handle[HW-1:0];
    assign h_idx    = r_handle[HW-1:0];
    assign s_idx    = r_scan[HW-1:0];
    assign rd_addr  = i_cmd.rd_scan ? s_idx : h_idx;
    assign is_lookup = (r_op == OP_LOOKUP);
    assign take     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_handle   <= i_handle;
            r_tag      <= i_user_tag;
            r_now      <= i_now_seconds;
            r_dl       <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            r_in_range <= in_range;
            r_present  <= in_range && r_valid[in_idx];
        end
    end

    ttw_rem #(
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (i_cmd.mod_src_now ? r_now : r_dl),
        .o_busy     (mod_busy),
        .o_rem      (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_armed <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_armed[h_idx] <= 1'b1;
                if (r_op == OP_CREATE) r_valid[h_idx] <= 1'b1;
            end
            if (i_cmd.do_cancel) r_armed[h_idx] <= 1'b0;
            if (i_cmd.do_free) begin
                r_valid[h_idx] <= 1'b0;
                r_armed[h_idx] <= 1'b0;
            end
            if (i_cmd.expire) begin
                r_valid[s_idx] <= 1'b0;
                r_armed[s_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.scan_clr) begin
            r_scan <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.scan_next) r_scan <= r_scan + 1'b1;
            if (i_cmd.expire)    r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem_dl[h_idx]   <= r_dl;
            mem_slot[h_idx] <= rem;
            if (r_op == OP_CREATE) mem_tag[h_idx] <= r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_dl   <= mem_dl[rd_addr];
            r_rd_tag  <= mem_tag[rd_addr];
            r_rd_slot <= mem_slot[rd_addr];
        end
    end

    always_comb begin
        case (r_op) inside
            OP_CREATE:                                err = !r_in_range;
            OP_REARM, OP_CANCEL, OP_FREE, OP_LOOKUP: err = !r_present;
            default:                                  err = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_resp || i_cmd.load_done || i_cmd.expire) begin
            o_valid <= 1'b1;
        end else if (take) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_resp) begin
            o_kind         <= is_lookup ? KIND_LOOKUP : KIND_ACK;
            o_status       <= err;
            o_out_handle   <= r_handle;
            o_out_tag      <= (is_lookup && r_present) ? r_rd_tag : '0;
            o_out_deadline <= (is_lookup && r_present) ? r_rd_dl : '0;
            o_present      <= is_lookup && r_present;
            o_armed        <= is_lookup && r_present && r_armed[h_idx];
            o_last         <= 1'b1;
        end else if (i_cmd.expire) begin
            o_kind         <= KIND_EXPIRED;
            o_status       <= 1'b0;
            o_out_handle   <= HANDLE_W'(s_idx);
            o_out_tag      <= r_rd_tag;
            o_out_deadline <= r_rd_dl;
            o_present      <= 1'b0;
            o_armed        <= 1'b0;
            o_last         <= 1'b0;
        end else if (i_cmd.load_done) begin
            o_kind         <= KIND_ACK;
            o_status       <= 1'b0;
            o_out_handle   <= '0;
            o_out_tag      <= '0;
            o_out_deadline <= '0;
            o_present      <= 1'b0;
            o_armed        <= 1'b0;
            o_last         <= 1'b1;
        end
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.in_range  = r_in_range;
        o_sts.present   = r_present;
        o_sts.mod_busy  = mod_busy;
        o_sts.hit       = r_valid[s_idx] && r_armed[s_idx] && (r_rd_slot == rem)
                          && (r_rd_dl <= r_now);
        o_sts.scan_end  = (r_scan == CW'(NUM_HANDLES)) || (r_cnt == CNT_W'(MAX_RESULTS - 1));
        o_sts.out_valid = o_valid;
    end

endmodule

`default_nettype wire

>>> test/ttw_expiry_checker.sv
// ----------------------------------------------------------------------------
// ttw_expiry_checker
// Watches both channels of the timeout table, keeps its own copy of the timer
// entries, works out the results of every accepted beat and compares each
// returned beat, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttw_expiry_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_dut_stall,
    input  logic [ttw_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic [ttw_pkg::HANDLE_W-1:0]        i_handle,
    input  logic [ttw_pkg::TAG_W-1:0]           i_user_tag,
    input  logic [ttw_pkg::DELAY_W-1:0]         i_delay_seconds,
    input  logic [ttw_pkg::TIME_W-1:0]          i_now_seconds,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [ttw_pkg::KIND_W-1:0]          i_kind,
    input  logic                                i_status,
    input  logic [ttw_pkg::HANDLE_W-1:0]        i_out_handle,
    input  logic [ttw_pkg::TAG_W-1:0]           i_out_tag,
    input  logic [ttw_pkg::TIME_W-1:0]          i_out_deadline,
    input  logic                                i_present,
    input  logic                                i_armed,
    input  logic                                i_last,
    output int                                  o_errors,
    output int                                  o_pending
);
    import ttw_pkg::*;

    localparam int NUM_TIMERS = DEF_NUM_HANDLES;
    localparam int SLOTS      = DEF_WHEEL_SLOTS;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                status;
        logic [HANDLE_W-1:0] hnd;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   deadline;
        logic                present;
        logic                armed;
        logic                last;
    } t_result;

    t_result             due_results[$];
    logic                tmr_valid[NUM_TIMERS];
    logic                tmr_armed[NUM_TIMERS];
    logic [TIME_W-1:0]   tmr_deadline[NUM_TIMERS];
    logic [TAG_W-1:0]    tmr_tag[NUM_TIMERS];

    function automatic logic [TIME_W-1:0] sat_deadline(logic [TIME_W-1:0] now,
                                                       logic [DELAY_W-1:0] dly);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, dly};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function automatic t_result mk(logic [KIND_W-1:0] kind, logic status,
                                   logic [HANDLE_W-1:0] hnd, logic [TAG_W-1:0] tag,
                                   logic [TIME_W-1:0] dl, logic present,
                                   logic armed, logic last);
        t_result r;
        r.kind = kind; r.status = status; r.hnd = hnd; r.tag = tag;
        r.deadline = dl; r.present = present; r.armed = armed; r.last = last;
        return r;
    endfunction

    task automatic apply_beat();
        logic [HANDLE_W-1:0] h;
        logic                here;
        int                  n;
        logic [TIME_W-1:0]   slot;
        h    = i_handle;
        here = (int'(h) < NUM_TIMERS) && tmr_valid[h];
        case (i_opcode)
            OP_CREATE: begin
                tmr_valid[h]    = 1'b1;
                tmr_armed[h]    = 1'b1;
                tmr_deadline[h] = sat_deadline(i_now_seconds, i_delay_seconds);
                tmr_tag[h]      = i_user_tag;
                due_results.push_back(mk(KIND_ACK, 1'b0, h, '0, '0, 1'b0, 1'b0, 1'b1));
            end
            OP_REARM, OP_CANCEL, OP_FREE: begin
                if (!here) begin
                    due_results.push_back(mk(KIND_ACK, 1'b1, h, '0, '0, 1'b0, 1'b0, 1'b1));
                end else begin
                    if (i_opcode == OP_REARM) begin
                        tmr_deadline[h] = sat_deadline(i_now_seconds, i_delay_seconds);
                        tmr_armed[h]    = 1'b1;
                    end else if (i_opcode == OP_CANCEL) begin
                        tmr_armed[h] = 1'b0;
                    end else begin
                        tmr_valid[h] = 1'b0;
                        tmr_armed[h] = 1'b0;
                    end
                    due_results.push_back(mk(KIND_ACK, 1'b0, h, '0, '0, 1'b0, 1'b0, 1'b1));
                end
            end
            OP_LOOKUP: begin
                if (!here) begin
                    due_results.push_back(mk(KIND_LOOKUP, 1'b1, h, '0, '0, 1'b0, 1'b0,
                                             1'b1));
                end else begin
                    due_results.push_back(mk(KIND_LOOKUP, 1'b0, h, tmr_tag[h],
                                             tmr_deadline[h], 1'b1, tmr_armed[h], 1'b1));
                end
            end
            OP_TICK: begin
                n    = 0;
                slot = i_now_seconds % SLOTS;
                for (int i = 0; i < NUM_TIMERS && n < MAX_RESULTS - 1; i++) begin
                    if (tmr_valid[i] && tmr_armed[i] && (tmr_deadline[i] % SLOTS == slot)
                        && tmr_deadline[i] <= i_now_seconds) begin
                        due_results.push_back(mk(KIND_EXPIRED, 1'b0, HANDLE_W'(i),
                                                 tmr_tag[i], tmr_deadline[i], 1'b0,
                                                 1'b0, 1'b0));
                        tmr_valid[i] = 1'b0;
                        tmr_armed[i] = 1'b0;
                        n++;
                    end
                end
                due_results.push_back(mk(KIND_ACK, 1'b0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
            end
            default: begin
                due_results.push_back(mk(KIND_ACK, 1'b0, h, '0, '0, 1'b0, 1'b0, 1'b1));
            end
        endcase
    endtask

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            o_errors++;
        end
    endtask

    task automatic check_beat();
        t_result w;
        if (due_results.size() == 0) begin
            $display("%0t ns: unexpected result beat, expected none, actual kind %0d",
                     $time, i_kind);
            o_errors++;
        end else begin
            w = due_results.pop_front();
            cmp_field("kind", 32'(w.kind), 32'(i_kind));
            cmp_field("status", 32'(w.status), 32'(i_status));
            cmp_field("handle", 32'(w.hnd), 32'(i_out_handle));
            cmp_field("tag", w.tag, i_out_tag);
            cmp_field("deadline", w.deadline, i_out_deadline);
            cmp_field("present", 32'(w.present), 32'(i_present));
            cmp_field("armed", 32'(w.armed), 32'(i_armed));
            cmp_field("last", 32'(w.last), 32'(i_last));
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_results.delete();
            for (int i = 0; i < NUM_TIMERS; i++) begin
                tmr_valid[i] = 1'b0;
                tmr_armed[i] = 1'b0;
            end
        end else begin
            if (i_valid && !i_dut_stall) begin
                apply_beat();
            end
            if (i_out_valid && !i_out_stall) begin
                check_beat();
            end
        end
        o_pending = due_results.size();
    end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the timeout table with directed and random timer operations under
// varying sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import ttw_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_B = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [OPCODE_W-1:0]   i_opcode;
    logic [HANDLE_W-1:0]   i_handle;
    logic [TAG_W-1:0]      i_user_tag;
    logic [DELAY_W-1:0]    i_delay_seconds;
    logic [TIME_W-1:0]     i_now_seconds;
    logic                  o_valid;
    logic                  i_stall;
    logic [KIND_W-1:0]     o_kind;
    logic                  o_status;
    logic [HANDLE_W-1:0]   o_out_handle;
    logic [TAG_W-1:0]      o_out_tag;
    logic [TIME_W-1:0]     o_out_deadline;
    logic                  o_present;
    logic                  o_armed;
    logic                  o_last;
    int                    fail_count;
    int                    results_due;
    int                    gap_pct;
    int                    stall_pct;
    int                    hold_left;
    logic [TIME_W-1:0]     wall_now;
    logic [TIME_W-1:0]     planned_dl[64];

    timing_wheel_timeout_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_handle(i_handle), .i_user_tag(i_user_tag),
        .i_delay_seconds(i_delay_seconds), .i_now_seconds(i_now_seconds),
        .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind), .o_status(o_status),
        .o_out_handle(o_out_handle), .o_out_tag(o_out_tag),
        .o_out_deadline(o_out_deadline), .o_present(o_present), .o_armed(o_armed),
        .o_last(o_last)
    );

    ttw_expiry_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_dut_stall(o_stall),
        .i_opcode(i_opcode), .i_handle(i_handle), .i_user_tag(i_user_tag),
        .i_delay_seconds(i_delay_seconds), .i_now_seconds(i_now_seconds),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_kind(o_kind),
        .i_status(o_status), .i_out_handle(o_out_handle), .i_out_tag(o_out_tag),
        .i_out_deadline(o_out_deadline), .i_present(o_present), .i_armed(o_armed),
        .i_last(o_last), .o_errors(fail_count), .o_pending(results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send(logic [OPCODE_W-1:0] op, logic [HANDLE_W-1:0] h,
                        logic [TAG_W-1:0] tag, logic [DELAY_W-1:0] dly,
                        logic [TIME_W-1:0] now);
        logic [TIME_W:0] sum;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        if (op == OP_CREATE || op == OP_REARM) begin
            sum           = {1'b0, now} + {9'd0, dly};
            planned_dl[h] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_handle        <= h;
        i_user_tag      <= tag;
        i_delay_seconds <= dly;
        i_now_seconds   <= now;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_op();
        int                  pick;
        logic [HANDLE_W-1:0] h;
        logic [DELAY_W-1:0]  dly;
        logic [TIME_W-1:0]   now;
        pick     = $urandom_range(0, 99);
        h        = HANDLE_W'($urandom_range(0, 63));
        wall_now = wall_now + $urandom_range(0, 20);
        now      = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : wall_now;
        dly      = ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom)
                                               : DELAY_W'($urandom_range(0, 150));
        if (pick < 28) begin
            send(OP_CREATE, h, $urandom, dly, now);
        end else if (pick < 40) begin
            send(OP_REARM, h, $urandom, dly, now);
        end else if (pick < 50) begin
            send(OP_CANCEL, h, $urandom, dly, now);
        end else if (pick < 57) begin
            send(OP_FREE, h, $urandom, dly, now);
        end else if (pick < 72) begin
            send(OP_LOOKUP, h, $urandom, dly, now);
        end else if (pick < 95) begin
            if ($urandom_range(0, 9) < 7) begin
                now = planned_dl[h] + 60 * $urandom_range(0, 1);
            end
            send(OP_TICK, h, $urandom, dly, now);
        end else begin
            send($urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B, h, $urandom, dly, now);
        end
    endtask

    task automatic crowd_burst(logic [TIME_W-1:0] base);
        for (int i = 0; i < 64; i++) begin
            send(OP_CREATE, HANDLE_W'(i), $urandom, 24'd30, base);
        end
        send(OP_TICK, '0, '0, '0, base + 30);
        send(OP_TICK, '0, '0, '0, base + 90);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_opcode        = OP_CREATE;
        i_handle        = '0;
        i_user_tag      = '0;
        i_delay_seconds = '0;
        i_now_seconds   = '0;
        gap_pct         = 0;
        stall_pct       = 0;
        hold_left       = 0;
        wall_now        = 32'd1000;
        for (int i = 0; i < 64; i++) planned_dl[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_CREATE, 6'd0, 32'h0, 24'd0, 32'd0);
        send(OP_LOOKUP, 6'd0, 32'h0, 24'd0, 32'd0);
        send(OP_CREATE, 6'd63, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFF0);
        send(OP_LOOKUP, 6'd63, 32'h0, 24'd0, 32'd0);
        send(OP_REARM, 6'd5, 32'h0, 24'd1, 32'd1);
        send(OP_CANCEL, 6'd5, 32'h0, 24'd0, 32'd0);
        send(OP_FREE, 6'd5, 32'h0, 24'd0, 32'd0);
        send(OP_LOOKUP, 6'd5, 32'h0, 24'd0, 32'd0);
        send(OP_CREATE, 6'd5, 32'hA5A5_5A5A, 24'd20, 32'd50);
        send(OP_CANCEL, 6'd5, 32'h0, 24'd0, 32'd0);
        send(OP_LOOKUP, 6'd5, 32'h0, 24'd0, 32'd0);
        send(OP_TICK, 6'd0, 32'h0, 24'd0, 32'd70);
        send(OP_REARM, 6'd5, 32'h0, 24'd10, 32'd100);
        send(OP_CREATE, 6'd7, 32'h1234_5678, 24'd170, 32'd10);
        send(OP_TICK, 6'd0, 32'h0, 24'd0, 32'd60);
        send(OP_TICK, 6'd0, 32'h0, 24'd0, 32'd110);
        send(OP_TICK, 6'd0, 32'h0, 24'd0, 32'd180);
        send(OP_UNUSED_A, 6'd9, 32'h0, 24'd0, 32'd0);
        send(OP_UNUSED_B, 6'd9, 32'h0, 24'd0, 32'd0);
        send(OP_TICK, 6'd0, 32'h0, 24'd0, 32'hFFFF_FFFF);
        send(OP_FREE, 6'd0, 32'h0, 24'd0, 32'd0);
        send(OP_LOOKUP, 6'd0, 32'h0, 24'd0, 32'd0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            gap_pct   = (phase == 1 || phase == 3) ? ((phase == 1) ? 49 : 22) : 0;
            stall_pct = (phase == 2) ? 49 : ((phase == 3) ? 22 : 0);
            if (phase == 0) begin
                hold_left = 600;
                crowd_burst(wall_now);
                wall_now = wall_now + 100;
            end
            for (int k = 0; k < 48; k++) random_op();
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (results_due != 0) @(posedge i_clk);
        end
        drain();

        if (fail_count == 0 && results_due == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ttw_pkg.sv
rtl/ttw_rem.sv
rtl/ttw_ctrl.sv
rtl/ttw_dp.sv
rtl/timing_wheel_timeout_table.sv
test/ttw_expiry_checker.sv
test/tb_top.sv
